// ===== rtl/cbf_pkg.sv =====
package cbf_pkg;

    typedef enum logic [2:0] {
        MODE_CLOSED = 3'b001,
        MODE_OPEN   = 3'b010,
        MODE_HALF   = 3'b100
    } t_mode;

    localparam logic [1:0] STATE_CODE_CLOSED = 2'd0;
    localparam logic [1:0] STATE_CODE_OPEN   = 2'd1;
    localparam logic [1:0] STATE_CODE_HALF   = 2'd2;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_REQ   = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    localparam logic [1:0] REG_FAILURE_LIMIT = 2'd0;
    localparam logic [1:0] REG_SUCCESS_LIMIT = 2'd1;
    localparam logic [1:0] REG_OPEN_TIMEOUT  = 2'd2;

    localparam logic [7:0]  FAILURE_LIMIT_RST = 8'd5;
    localparam logic [7:0]  SUCCESS_LIMIT_RST = 8'd2;
    localparam logic [31:0] OPEN_TIMEOUT_RST  = 32'd10000;

    localparam int APB_AW = 4;

    typedef struct packed {
        logic [7:0]  failure_limit;
        logic [7:0]  success_limit;
        logic [31:0] open_timeout_ticks;
    } t_cfg;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        sat_inc8 = (v == '1) ? v : v + 8'd1;
    endfunction

    function automatic logic [1:0] mode_code(input t_mode m);
        case (m)
            MODE_OPEN: mode_code = STATE_CODE_OPEN;
            MODE_HALF: mode_code = STATE_CODE_HALF;
            default:   mode_code = STATE_CODE_CLOSED;
        endcase
    endfunction

endpackage

// ===== rtl/cbf_if.sv =====
interface cbf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       op_ok;

    modport source (output valid, output req_type, output op_ok, input ready);
    modport sink   (input valid, input req_type, input op_ok, output ready);
endinterface

interface cbf_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  breaker_state;
    logic        admitted;
    logic        rejected;
    logic [7:0]  fail_count;
    logic [7:0]  ok_count;
    logic [31:0] total_seen;
    logic [31:0] total_ok;
    logic [31:0] total_failed;
    logic [31:0] total_rejected;

    modport source (
        output valid, output breaker_state, output admitted, output rejected,
        output fail_count, output ok_count, output total_seen, output total_ok,
        output total_failed, output total_rejected, input ready
    );
    modport sink (
        input valid, input breaker_state, input admitted, input rejected,
        input fail_count, input ok_count, input total_seen, input total_ok,
        input total_failed, input total_rejected, output ready
    );
endinterface

// ===== rtl/cbf_regs.sv =====
module cbf_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cbf_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output cbf_pkg::t_cfg              o_cfg
);
    import cbf_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.failure_limit      <= FAILURE_LIMIT_RST;
            r_cfg.success_limit      <= SUCCESS_LIMIT_RST;
            r_cfg.open_timeout_ticks <= OPEN_TIMEOUT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FAILURE_LIMIT: r_cfg.failure_limit      <= pwdata[7:0];
                REG_SUCCESS_LIMIT: r_cfg.success_limit      <= pwdata[7:0];
                REG_OPEN_TIMEOUT:  r_cfg.open_timeout_ticks <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FAILURE_LIMIT: prdata = {24'd0, r_cfg.failure_limit};
            REG_SUCCESS_LIMIT: prdata = {24'd0, r_cfg.success_limit};
            REG_OPEN_TIMEOUT:  prdata = r_cfg.open_timeout_ticks;
            default:           prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/circuit_breaker_fsm.sv =====
// Three-state circuit breaker, one request per item.
// A request passes through the input register, then the response register holding
// the updated breaker state.
// Throughput: 1 request per cycle; both stages advance when the response register is free or taken.
// Reset (i_rst_n low, synchronous): breaker closed, all counts and statistics
// zero, config registers at their defaults, both stages empty.
module circuit_breaker_fsm (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cbf_req_if.sink                    i_req,
    cbf_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cbf_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import cbf_pkg::*;

    t_cfg cfg;

    cbf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input stage
    logic       r_in_vld;
    logic [1:0] r_in_type;
    logic       r_in_ok;

    // breaker state
    t_mode       r_mode;
    logic [7:0]  r_fails;
    logic [7:0]  r_oks;
    logic [31:0] r_since;
    logic [31:0] r_total;
    logic [31:0] r_stat_ok;
    logic [31:0] r_stat_fail;
    logic [31:0] r_stat_rej;

    // response stage
    logic r_out_vld;
    logic r_out_adm;
    logic r_out_rej;

    t_mode       n_mode;
    logic [7:0]  n_fails;
    logic [7:0]  n_oks;
    logic [31:0] n_since;
    logic [31:0] n_total;
    logic [31:0] n_stat_ok;
    logic [31:0] n_stat_fail;
    logic [31:0] n_stat_rej;
    logic        n_adm;
    logic        n_rej;

    logic advance;

    assign advance     = r_in_vld & (~r_out_vld | o_rsp.ready);
    assign i_req.ready = ~r_in_vld | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_type <= i_req.req_type;
            r_in_ok   <= i_req.op_ok;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_fails     = r_fails;
        n_oks       = r_oks;
        n_since     = r_since;
        n_total     = r_total;
        n_stat_ok   = r_stat_ok;
        n_stat_fail = r_stat_fail;
        n_stat_rej  = r_stat_rej;
        n_adm       = 1'b0;
        n_rej       = 1'b0;
        case (r_in_type)
            KIND_TICK: begin
                n_since = sat_inc32(r_since);
            end
            KIND_RESET: begin
                n_mode  = MODE_CLOSED;
                n_fails = 8'd0;
                n_oks   = 8'd0;
            end
            KIND_REQ: begin
                n_total = sat_inc32(r_total);
                n_adm   = 1'b1;
                if (r_mode == MODE_OPEN) begin
                    if (r_since >= cfg.open_timeout_ticks) begin
                        n_mode = MODE_HALF;
                    end else begin
                        n_adm      = 1'b0;
                        n_rej      = 1'b1;
                        n_stat_rej = sat_inc32(r_stat_rej);
                    end
                end
                if (n_adm) begin
                    if (r_in_ok) begin
                        n_stat_ok = sat_inc32(r_stat_ok);
                        if (n_mode == MODE_HALF) begin
                            n_oks = sat_inc8(r_oks);
                            if (n_oks >= cfg.success_limit) begin
                                n_mode  = MODE_CLOSED;
                                n_fails = 8'd0;
                                n_oks   = 8'd0;
                            end
                        end else if (n_mode == MODE_CLOSED) begin
                            n_fails = 8'd0;
                        end
                    end else begin
                        n_stat_fail = sat_inc32(r_stat_fail);
                        n_since     = 32'd0;
                        if (n_mode == MODE_HALF) begin
                            n_mode = MODE_OPEN;
                            n_oks  = 8'd0;
                        end else if (n_mode == MODE_CLOSED) begin
                            n_fails = sat_inc8(r_fails);
                            if (n_fails >= cfg.failure_limit) begin
                                n_mode = MODE_OPEN;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_CLOSED;
            r_fails     <= 8'd0;
            r_oks       <= 8'd0;
            r_since     <= 32'd0;
            r_total     <= 32'd0;
            r_stat_ok   <= 32'd0;
            r_stat_fail <= 32'd0;
            r_stat_rej  <= 32'd0;
            r_out_vld   <= 1'b0;
        end else begin
            if (advance) begin
                r_mode      <= n_mode;
                r_fails     <= n_fails;
                r_oks       <= n_oks;
                r_since     <= n_since;
                r_total     <= n_total;
                r_stat_ok   <= n_stat_ok;
                r_stat_fail <= n_stat_fail;
                r_stat_rej  <= n_stat_rej;
                r_out_vld   <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_adm <= n_adm;
            r_out_rej <= n_rej;
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.breaker_state  = mode_code(r_mode);
    assign o_rsp.admitted       = r_out_adm;
    assign o_rsp.rejected       = r_out_rej;
    assign o_rsp.fail_count     = r_fails;
    assign o_rsp.ok_count       = r_oks;
    assign o_rsp.total_seen     = r_total;
    assign o_rsp.total_ok       = r_stat_ok;
    assign o_rsp.total_failed   = r_stat_fail;
    assign o_rsp.total_rejected = r_stat_rej;

endmodule

// ===== verif/circuit_breaker_fsm_tb.sv =====
module circuit_breaker_fsm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbf_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  state;
        logic        admitted;
        logic        rejected;
        logic [7:0]  fail_cnt;
        logic [7:0]  ok_cnt;
        logic [31:0] seen;
        logic [31:0] passed;
        logic [31:0] failed;
        logic [31:0] refused;
    } t_breaker_status;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    cbf_req_if req_ch();
    cbf_rsp_if rsp_ch();

    circuit_breaker_fsm u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // predicted breaker state and its settings
    t_cfg        brk_cfg;
    logic [1:0]  brk_mode;
    logic [7:0]  brk_fails;
    logic [7:0]  brk_trials;
    logic [31:0] brk_since;
    logic [31:0] cnt_total;
    logic [31:0] cnt_ok;
    logic [31:0] cnt_failed;
    logic [31:0] cnt_rejected;

    t_breaker_status pending_status_q[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold_cycles = 0;
    int fail_pct = 50;

    function automatic t_breaker_status step_breaker(input logic [1:0] kind, input logic ok);
        t_breaker_status s;
        s = '0;
        case (kind)
            KIND_TICK: begin
                brk_since = (brk_since == '1) ? brk_since : brk_since + 32'd1;
            end
            KIND_RESET: begin
                brk_mode = STATE_CODE_CLOSED;
                brk_fails = '0;
                brk_trials = '0;
            end
            KIND_REQ: begin
                cnt_total = (cnt_total == '1) ? cnt_total : cnt_total + 32'd1;
                s.admitted = 1'b1;
                if (brk_mode == STATE_CODE_OPEN) begin
                    if (brk_since >= brk_cfg.open_timeout_ticks) begin
                        brk_mode = STATE_CODE_HALF;
                    end else begin
                        s.admitted = 1'b0;
                        s.rejected = 1'b1;
                        cnt_rejected = (cnt_rejected == '1) ? cnt_rejected
                                                            : cnt_rejected + 32'd1;
                    end
                end
                if (s.admitted && ok) begin
                    cnt_ok = (cnt_ok == '1) ? cnt_ok : cnt_ok + 32'd1;
                    if (brk_mode == STATE_CODE_HALF) begin
                        brk_trials = (brk_trials == '1) ? brk_trials : brk_trials + 8'd1;
                        if (brk_trials >= brk_cfg.success_limit) begin
                            brk_mode = STATE_CODE_CLOSED;
                            brk_fails = '0;
                            brk_trials = '0;
                        end
                    end else if (brk_mode == STATE_CODE_CLOSED) begin
                        brk_fails = '0;
                    end
                end else if (s.admitted) begin
                    cnt_failed = (cnt_failed == '1) ? cnt_failed : cnt_failed + 32'd1;
                    brk_since = '0;
                    if (brk_mode == STATE_CODE_HALF) begin
                        brk_mode = STATE_CODE_OPEN;
                        brk_trials = '0;
                    end else if (brk_mode == STATE_CODE_CLOSED) begin
                        brk_fails = (brk_fails == '1) ? brk_fails : brk_fails + 8'd1;
                        if (brk_fails >= brk_cfg.failure_limit) begin
                            brk_mode = STATE_CODE_OPEN;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        s.state = brk_mode;
        s.fail_cnt = brk_fails;
        s.ok_cnt = brk_trials;
        s.seen = cnt_total;
        s.passed = cnt_ok;
        s.failed = cnt_failed;
        s.refused = cnt_rejected;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_breaker_status want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_status_q.size() == 0) begin
                $display("%0t: response with none pending, state %0h",
                         $time, rsp_ch.breaker_state);
                mismatches++;
            end else begin
                want = pending_status_q.pop_front();
                check_field("breaker_state", 32'(want.state), 32'(rsp_ch.breaker_state));
                check_field("admitted", 32'(want.admitted), 32'(rsp_ch.admitted));
                check_field("rejected", 32'(want.rejected), 32'(rsp_ch.rejected));
                check_field("fail_count", 32'(want.fail_cnt), 32'(rsp_ch.fail_count));
                check_field("ok_count", 32'(want.ok_cnt), 32'(rsp_ch.ok_count));
                check_field("total_seen", want.seen, rsp_ch.total_seen);
                check_field("total_ok", want.passed, rsp_ch.total_ok);
                check_field("total_failed", want.failed, rsp_ch.total_failed);
                check_field("total_rejected", want.refused, rsp_ch.total_rejected);
            end
        end
    end

    // response side: long hold-off when asked, else random stalls
    always @(negedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            sink_hold_cycles--;
        end else begin
            rsp_ch.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic ok);
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            repeat ($urandom_range(2)) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid = 1'b1;
        req_ch.req_type = kind;
        req_ch.op_ok = ok;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pending_status_q.push_back(step_breaker(kind, ok));
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        // alternate between failure-heavy and recovery-heavy stretches
        if ($urandom_range(19) == 0) fail_pct = (fail_pct > 50) ? 15 : 75;
        if (pick < 30) send_request(KIND_TICK, 1'($urandom_range(1)));
        else if (pick < 93) send_request(KIND_REQ, $urandom_range(99) >= fail_pct);
        else if (pick < 98) send_request(KIND_RESET, 1'($urandom_range(1)));
        else send_request(KIND_UNUSED, 1'($urandom_range(1)));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] stored;
        logic [31:0] readback;
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_FAILURE_LIMIT: begin
                brk_cfg.failure_limit = value[7:0];
                stored = {24'd0, value[7:0]};
            end
            REG_SUCCESS_LIMIT: begin
                brk_cfg.success_limit = value[7:0];
                stored = {24'd0, value[7:0]};
            end
            default: begin
                brk_cfg.open_timeout_ticks = value;
                stored = value;
            end
        endcase
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        readback = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (readback !== stored) begin
            $display("%0t: register %0d expected %0h got %0h", $time, idx, stored, readback);
            mismatches++;
        end
    endtask

    task automatic set_config(input logic [7:0] fail_lim, input logic [7:0] ok_lim,
                              input logic [31:0] timeout);
        wait_drained();
        write_reg(REG_FAILURE_LIMIT, {24'd0, fail_lim});
        write_reg(REG_SUCCESS_LIMIT, {24'd0, ok_lim});
        write_reg(REG_OPEN_TIMEOUT, timeout);
    endtask

    // reset values: open after five failures, op_ok ignored on refusals,
    // unused kind and manual reset
    task automatic test_defaults();
        send_request(KIND_REQ, 1'b1);
        repeat (5) send_request(KIND_REQ, 1'b0);
        send_request(KIND_REQ, 1'b1);
        send_request(KIND_TICK, 1'b1);
        send_request(KIND_UNUSED, 1'b1);
        send_request(KIND_RESET, 1'b1);
        send_request(KIND_TICK, 1'b0);
        send_request(KIND_REQ, 1'b0);
    endtask

    // zero limits and zero timeout: first matching outcome trips
    task automatic test_zero_limits();
        set_config(8'd0, 8'd0, 32'd0);
        send_request(KIND_REQ, 1'b0);
        send_request(KIND_REQ, 1'b1);
        send_request(KIND_REQ, 1'b1);
        send_request(KIND_TICK, 1'b0);
        send_request(KIND_REQ, 1'b0);
        send_request(KIND_REQ, 1'b0);
        send_request(KIND_REQ, 1'b1);
    endtask

    // both 8-bit counts up to 255, then a timeout that never expires
    task automatic test_count_ceiling();
        send_idle_pct = 20;
        sink_stall_pct = 20;
        set_config(8'd255, 8'd255, 32'd2);
        repeat (256) begin
            if ($urandom_range(9) == 0) send_request(KIND_TICK, 1'($urandom_range(1)));
            send_request(KIND_REQ, 1'b0);
        end
        repeat (2) send_request(KIND_TICK, 1'b0);
        repeat (256) begin
            if ($urandom_range(9) == 0) send_request(KIND_TICK, 1'($urandom_range(1)));
            send_request(KIND_REQ, 1'b1);
        end
        set_config(8'd1, 8'd255, 32'hFFFF_FFFF);
        send_request(KIND_REQ, 1'b0);
        repeat (4) begin
            send_request(KIND_TICK, 1'($urandom_range(1)));
            send_request(KIND_REQ, 1'($urandom_range(1)));
        end
        send_request(KIND_RESET, 1'b0);
    endtask

    // response side held off so the pipeline fills and stalls the input
    task automatic test_backpressure();
        send_idle_pct = 0;
        sink_stall_pct = 0;
        set_config(8'd2, 8'd1, 32'd3);
        @(posedge i_clk);
        sink_hold_cycles = 60;
        repeat (40) send_random_item();
        wait_drained();
        repeat (10) send_random_item();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct, input logic [7:0] fail_lim,
                                       input logic [7:0] ok_lim, input logic [31:0] timeout);
        set_config(fail_lim, ok_lim, timeout);
        send_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count) send_random_item();
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = KIND_TICK;
        req_ch.op_ok = 1'b0;
        rsp_ch.ready = 1'b0;
        brk_cfg.failure_limit = FAILURE_LIMIT_RST;
        brk_cfg.success_limit = SUCCESS_LIMIT_RST;
        brk_cfg.open_timeout_ticks = OPEN_TIMEOUT_RST;
        brk_mode = STATE_CODE_CLOSED;
        brk_fails = '0;
        brk_trials = '0;
        brk_since = '0;
        cnt_total = '0;
        cnt_ok = '0;
        cnt_failed = '0;
        cnt_rejected = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_defaults();
        test_zero_limits();
        test_count_ceiling();
        test_backpressure();
        test_random_traffic(300, 0, 0, 8'($urandom_range(6, 1)), 8'($urandom_range(4, 1)),
                            $urandom_range(6, 0));
        test_random_traffic(300, 56, 0, 8'd1, 8'd1, 32'd0);
        test_random_traffic(300, 0, 56, 8'($urandom_range(6, 1)), 8'($urandom_range(4, 1)),
                            $urandom_range(8, 0));
        test_random_traffic(300, 32, 32, 8'($urandom_range(6, 1)), 8'($urandom_range(4, 1)),
                            $urandom_range(8, 0));

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("circuit_breaker_fsm_tb: PASS");
        end else begin
            $display("circuit_breaker_fsm_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #1_600_000;
        $display("circuit_breaker_fsm_tb: FAIL");
        $finish;
    end

endmodule

// ===== circuit_breaker_fsm.f =====
rtl/cbf_pkg.sv
rtl/cbf_if.sv
rtl/cbf_regs.sv
rtl/circuit_breaker_fsm.sv
verif/circuit_breaker_fsm_tb.sv
